@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the checker modules of this block.
// Stands alone; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst_n is low.
`define GN2D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, also while reset is applied.
`define GN2D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/gn2d_pkg.sv @@
// Types, constants and arithmetic helpers of the 2D gradient noise unit.
// No dependencies; used by every module of the block.
package gn2d_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PERM_W     = 8;
  localparam int GRAD_W     = 16;
  localparam int OUT_W      = 20;
  localparam int UW         = 19;
  localparam int SUM_W      = 26;

  typedef enum logic [1:0] {
    OP_WR_PERM = 2'd0,
    OP_WR_GRAD = 2'd1,
    OP_EVAL    = 2'd2
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [7:0]               table_index;
    logic [7:0]               perm_value;
    logic signed [GRAD_W-1:0] grad_x_in;
    logic signed [GRAD_W-1:0] grad_y_in;
    logic signed [31:0]       point_x;
    logic signed [31:0]       point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] noise_value;
    logic signed [OUT_W-1:0] deriv_x;
    logic signed [OUT_W-1:0] deriv_y;
  } out_item_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] ax;
    logic signed [GRAD_W-1:0] ay;
    logic signed [GRAD_W-1:0] bx;
    logic signed [GRAD_W-1:0] by;
    logic signed [GRAD_W-1:0] cx;
    logic signed [GRAD_W-1:0] cy;
    logic signed [GRAD_W-1:0] dx;
    logic signed [GRAD_W-1:0] dy;
  } corner_grads_t;

  // Q16 product, rounded half up, floor shift.
  function automatic logic signed [31:0] qmul(input logic signed [23:0] a,
                                              input logic signed [23:0] b);
    logic signed [47:0] p;
    p = a * b + 48'sd32768;
    return p[47:16];
  endfunction

  // Dot product of a Q1.14 gradient with a Q16 offset, result in Q16.
  function automatic logic signed [19:0] dot14(input logic signed [15:0] gx,
                                               input logic signed [15:0] gy,
                                               input logic signed [17:0] dx,
                                               input logic signed [17:0] dy);
    logic signed [34:0] s;
    s = gx * dx + gy * dy + 35'sd8192;
    return s[33:14];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] x);
    logic signed [OUT_W-1:0] r;
    if (x > 26'sd524287) begin
      r = 20'sd524287;
    end else if (x < -26'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = x[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/gn2d_fade.sv @@
// Three-stage quintic fade and fade slope for one Q0.16 fraction.
// Depends on gn2d_pkg.
module gn2d_fade (
  input  logic                            clk,
  input  logic                            en,
  input  logic [15:0]                     f_in,
  output logic [15:0]                     f_out,
  output logic signed [gn2d_pkg::UW-1:0]  u_out,
  output logic signed [gn2d_pkg::UW-1:0]  du_out
);

  logic signed [16:0] fs;
  logic signed [21:0] lin6;
  logic signed [17:0] lin2;
  logic signed [31:0] q_f2, q_t, q_t2, q_f3, q_u, q_du;

  logic [15:0]        fa_r, fb_r;
  logic signed [16:0] f2a_r, f2b_r, f3_r;
  logic signed [20:0] t_r;
  logic signed [17:0] t2_r;
  logic signed [21:0] inner_r;
  logic signed [17:0] inner2_r;
  logic [15:0]        fc_r;
  logic signed [gn2d_pkg::UW-1:0] u_r, du_r;

  function automatic logic signed [gn2d_pkg::UW-1:0] UW_MUL30(
      input logic signed [gn2d_pkg::UW-1:0] x);
    return (x <<< 5) - (x <<< 1);
  endfunction

  assign fs   = $signed({1'b0, f_in});
  assign lin6 = 22'(fs) * 22'sd6 - 22'sd983040;
  assign lin2 = 18'(fs) - 18'sd131072;
  assign q_f2 = gn2d_pkg::qmul(24'(fs), 24'(fs));
  assign q_t  = gn2d_pkg::qmul(24'(fs), 24'(lin6));
  assign q_t2 = gn2d_pkg::qmul(24'(fs), 24'(lin2));
  assign q_f3 = gn2d_pkg::qmul(24'(f2a_r), 24'($signed({1'b0, fa_r})));
  assign q_u  = gn2d_pkg::qmul(24'(f3_r), 24'(inner_r));
  assign q_du = gn2d_pkg::qmul(24'(f2b_r), 24'(inner2_r));

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r     <= f_in;
      f2a_r    <= q_f2[16:0];
      t_r      <= q_t[20:0];
      t2_r     <= q_t2[17:0];
      fb_r     <= fa_r;
      f2b_r    <= f2a_r;
      f3_r     <= q_f3[16:0];
      inner_r  <= 22'(t_r) + 22'sd655360;
      inner2_r <= t2_r + 18'sd65536;
      fc_r     <= fb_r;
      u_r      <= q_u[gn2d_pkg::UW-1:0];
      du_r     <= UW_MUL30(q_du[gn2d_pkg::UW-1:0]);
    end
  end

  assign f_out  = fc_r;
  assign u_out  = u_r;
  assign du_out = du_r;

endmodule

@@ rtl/core/gn2d_hash.sv @@
// Corner hashing and table lookups: three stages over replicated tables.
// Depends on gn2d_pkg.
module gn2d_hash (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [gn2d_pkg::IDX_W-1:0]     seed,
  input  logic                           valid1,
  input  gn2d_pkg::in_item_t             item1,
  output logic                           eval4,
  output gn2d_pkg::corner_grads_t        grads4
);

  localparam int IW = gn2d_pkg::IDX_W;
  localparam int PW = gn2d_pkg::PERM_W;
  localparam int GW = 2 * gn2d_pkg::GRAD_W;
  localparam int TS = gn2d_pkg::TABLE_SIZE;

  // Each table is held in copies so that every lookup port sees one
  // write port and at most two read ports. A copy is written when a load
  // transaction reaches the stage that reads it, which keeps loads and
  // evaluations in order.
  logic [PW-1:0] perm_a [0:TS-1];
  logic [PW-1:0] perm_b [0:TS-1];
  logic [PW-1:0] perm_c [0:TS-1];
  logic [GW-1:0] grad_d [0:TS-1];
  logic [GW-1:0] grad_e [0:TS-1];

  logic [IW-1:0] idx1, c0a, c0b, c1a, c1b, c1c, c1d;
  logic          v2_r, v3_r, v4_r;
  gn2d_pkg::op_t op2_r, op3_r, op4_r;
  logic [IW-1:0] idx2_r, idx3_r, iy2_r;
  logic [PW-1:0] pv2_r;
  logic [GW-1:0] gxy2_r, gxy3_r;
  logic [PW-1:0] pa_r, pb_r, ha_r, hb_r, hc_r, hd_r;
  logic [GW-1:0] ga_r, gb_r, gc_r, gd_r;

  assign idx1 = IW'(item1.table_index);
  assign c0a  = IW'(item1.point_x[31:16]) + seed;
  assign c0b  = c0a + IW'(1);
  assign c1a  = IW'(pa_r) + iy2_r + seed;
  assign c1b  = IW'(pb_r) + iy2_r + seed;
  assign c1c  = c1a + IW'(1);
  assign c1d  = c1b + IW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (valid1 && item1.op == gn2d_pkg::OP_WR_PERM) begin
        perm_a[idx1] <= item1.perm_value;
      end
      pa_r <= perm_a[c0a];
      pb_r <= perm_a[c0b];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v2_r && op2_r == gn2d_pkg::OP_WR_PERM) begin
        perm_b[idx2_r] <= pv2_r;
        perm_c[idx2_r] <= pv2_r;
      end
      ha_r <= perm_b[c1a];
      hb_r <= perm_b[c1b];
      hc_r <= perm_c[c1c];
      hd_r <= perm_c[c1d];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (v3_r && op3_r == gn2d_pkg::OP_WR_GRAD) begin
        grad_d[idx3_r] <= gxy3_r;
        grad_e[idx3_r] <= gxy3_r;
      end
      ga_r <= grad_d[IW'(ha_r)];
      gb_r <= grad_d[IW'(hb_r)];
      gc_r <= grad_e[IW'(hc_r)];
      gd_r <= grad_e[IW'(hd_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v2_r <= valid1;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= item1.op;
      idx2_r <= idx1;
      pv2_r  <= item1.perm_value;
      gxy2_r <= {item1.grad_y_in, item1.grad_x_in};
      iy2_r  <= IW'(item1.point_y[31:16]);
      op3_r  <= op2_r;
      idx3_r <= idx2_r;
      gxy3_r <= gxy2_r;
      op4_r  <= op3_r;
    end
  end

  assign eval4     = v4_r && op4_r == gn2d_pkg::OP_EVAL;
  assign grads4.ax = ga_r[15:0];
  assign grads4.ay = ga_r[31:16];
  assign grads4.bx = gb_r[15:0];
  assign grads4.by = gb_r[31:16];
  assign grads4.cx = gc_r[15:0];
  assign grads4.cy = gc_r[31:16];
  assign grads4.dx = gd_r[15:0];
  assign grads4.dy = gd_r[31:16];

endmodule

@@ rtl/core/gn2d_blend.sv @@
// Dot products, fade blend and saturation: five stages ending in the
// result register. Depends on gn2d_pkg.
module gn2d_blend (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            valid4,
  input  gn2d_pkg::corner_grads_t         g,
  input  logic [15:0]                     fx,
  input  logic [15:0]                     fy,
  input  logic signed [gn2d_pkg::UW-1:0]  ux,
  input  logic signed [gn2d_pkg::UW-1:0]  uy,
  input  logic signed [gn2d_pkg::UW-1:0]  dux,
  input  logic signed [gn2d_pkg::UW-1:0]  duy,
  output logic                            out_valid,
  output gn2d_pkg::out_item_t             out_item
);

  localparam int UW = gn2d_pkg::UW;
  localparam int SW = gn2d_pkg::SUM_W;

  logic v5_r, v6_r, v7_r, v8_r, v9_r;

  // Stage 4 -> 5
  logic signed [17:0] fx0, fx1, fy0, fy1;
  logic signed [17:0] ax4, ay4, bx4, by4, cx4, cy4, dx4, dy4;
  logic signed [31:0] q_uxy;
  logic signed [19:0] va5_r, vb5_r, vc5_r, vd5_r;
  logic signed [UW-1:0] ux5_r, uy5_r, uxy5_r, dux5_r, duy5_r;
  logic signed [17:0] ax5_r, ay5_r;
  logic signed [18:0] e1x5_r, e2x5_r, e1y5_r, e2y5_r;
  logic signed [19:0] e3x5_r, e3y5_r;

  // Stage 5 -> 6
  logic signed [31:0] q_p1x, q_p2x, q_p3x, q_p1y, q_p2y, q_p3y;
  logic signed [21:0] k6_r;
  logic signed [20:0] dba6_r, dca6_r;
  logic signed [19:0] va6_r;
  logic signed [UW-1:0] ux6_r, uy6_r, uxy6_r, dux6_r, duy6_r;
  logic signed [17:0] ax6_r, ay6_r;
  logic signed [20:0] p1x6_r, p2x6_r, p3x6_r, p1y6_r, p2y6_r, p3y6_r;

  // Stage 6 -> 7
  logic signed [31:0] q_n1, q_n2, q_n3, q_uyk, q_uxk;
  logic signed [22:0] n1_7_r, n2_7_r, n3_7_r, uyk7_r, uxk7_r;
  logic signed [19:0] va7_r;
  logic signed [20:0] dba7_r, dca7_r;
  logic signed [UW-1:0] dux7_r, duy7_r;
  logic signed [SW-1:0] sx7_r, sy7_r;

  // Stage 7 -> 8
  logic signed [31:0] q_tx, q_ty;
  logic signed [SW-1:0] v8_val_r, tx8_r, ty8_r, sx8_r, sy8_r;

  gn2d_pkg::out_item_t out_r;

  assign fx0 = $signed({2'b00, fx});
  assign fy0 = $signed({2'b00, fy});
  assign fx1 = fx0 - 18'sd65536;
  assign fy1 = fy0 - 18'sd65536;
  assign ax4 = $signed({g.ax, 2'b00});
  assign ay4 = $signed({g.ay, 2'b00});
  assign bx4 = $signed({g.bx, 2'b00});
  assign by4 = $signed({g.by, 2'b00});
  assign cx4 = $signed({g.cx, 2'b00});
  assign cy4 = $signed({g.cy, 2'b00});
  assign dx4 = $signed({g.dx, 2'b00});
  assign dy4 = $signed({g.dy, 2'b00});
  assign q_uxy = gn2d_pkg::qmul(24'(ux), 24'(uy));

  always_ff @(posedge clk) begin
    if (en) begin
      va5_r  <= gn2d_pkg::dot14(g.ax, g.ay, fx0, fy0);
      vb5_r  <= gn2d_pkg::dot14(g.bx, g.by, fx1, fy0);
      vc5_r  <= gn2d_pkg::dot14(g.cx, g.cy, fx0, fy1);
      vd5_r  <= gn2d_pkg::dot14(g.dx, g.dy, fx1, fy1);
      uxy5_r <= q_uxy[UW-1:0];
      ux5_r  <= ux;
      uy5_r  <= uy;
      dux5_r <= dux;
      duy5_r <= duy;
      ax5_r  <= ax4;
      ay5_r  <= ay4;
      e1x5_r <= 19'(bx4) - 19'(ax4);
      e2x5_r <= 19'(cx4) - 19'(ax4);
      e3x5_r <= 20'(ax4) - 20'(bx4) - 20'(cx4) + 20'(dx4);
      e1y5_r <= 19'(by4) - 19'(ay4);
      e2y5_r <= 19'(cy4) - 19'(ay4);
      e3y5_r <= 20'(ay4) - 20'(by4) - 20'(cy4) + 20'(dy4);
    end
  end

  assign q_p1x = gn2d_pkg::qmul(24'(ux5_r), 24'(e1x5_r));
  assign q_p2x = gn2d_pkg::qmul(24'(uy5_r), 24'(e2x5_r));
  assign q_p3x = gn2d_pkg::qmul(24'(uxy5_r), 24'(e3x5_r));
  assign q_p1y = gn2d_pkg::qmul(24'(ux5_r), 24'(e1y5_r));
  assign q_p2y = gn2d_pkg::qmul(24'(uy5_r), 24'(e2y5_r));
  assign q_p3y = gn2d_pkg::qmul(24'(uxy5_r), 24'(e3y5_r));

  always_ff @(posedge clk) begin
    if (en) begin
      k6_r   <= 22'(va5_r) - 22'(vb5_r) - 22'(vc5_r) + 22'(vd5_r);
      dba6_r <= 21'(vb5_r) - 21'(va5_r);
      dca6_r <= 21'(vc5_r) - 21'(va5_r);
      va6_r  <= va5_r;
      ux6_r  <= ux5_r;
      uy6_r  <= uy5_r;
      uxy6_r <= uxy5_r;
      dux6_r <= dux5_r;
      duy6_r <= duy5_r;
      ax6_r  <= ax5_r;
      ay6_r  <= ay5_r;
      p1x6_r <= q_p1x[20:0];
      p2x6_r <= q_p2x[20:0];
      p3x6_r <= q_p3x[20:0];
      p1y6_r <= q_p1y[20:0];
      p2y6_r <= q_p2y[20:0];
      p3y6_r <= q_p3y[20:0];
    end
  end

  assign q_n1  = gn2d_pkg::qmul(24'(ux6_r), 24'(dba6_r));
  assign q_n2  = gn2d_pkg::qmul(24'(uy6_r), 24'(dca6_r));
  assign q_n3  = gn2d_pkg::qmul(24'(uxy6_r), 24'(k6_r));
  assign q_uyk = gn2d_pkg::qmul(24'(uy6_r), 24'(k6_r));
  assign q_uxk = gn2d_pkg::qmul(24'(ux6_r), 24'(k6_r));

  always_ff @(posedge clk) begin
    if (en) begin
      n1_7_r <= q_n1[22:0];
      n2_7_r <= q_n2[22:0];
      n3_7_r <= q_n3[22:0];
      uyk7_r <= q_uyk[22:0];
      uxk7_r <= q_uxk[22:0];
      va7_r  <= va6_r;
      dba7_r <= dba6_r;
      dca7_r <= dca6_r;
      dux7_r <= dux6_r;
      duy7_r <= duy6_r;
      sx7_r  <= SW'(ax6_r) + SW'(p1x6_r) + SW'(p2x6_r) + SW'(p3x6_r);
      sy7_r  <= SW'(ay6_r) + SW'(p1y6_r) + SW'(p2y6_r) + SW'(p3y6_r);
    end
  end

  assign q_tx = gn2d_pkg::qmul(24'(dux7_r), 24'(uyk7_r) + 24'(dba7_r));
  assign q_ty = gn2d_pkg::qmul(24'(duy7_r), 24'(uxk7_r) + 24'(dca7_r));

  always_ff @(posedge clk) begin
    if (en) begin
      v8_val_r <= SW'(va7_r) + SW'(n1_7_r) + SW'(n2_7_r) + SW'(n3_7_r);
      tx8_r    <= q_tx[SW-1:0];
      ty8_r    <= q_ty[SW-1:0];
      sx8_r    <= sx7_r;
      sy8_r    <= sy7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.noise_value <= gn2d_pkg::sat_out(v8_val_r);
      out_r.deriv_x     <= gn2d_pkg::sat_out(sx8_r + tx8_r);
      out_r.deriv_y     <= gn2d_pkg::sat_out(sy8_r + ty8_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v5_r <= valid4;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  assign out_valid = v9_r;
  assign out_item  = out_r;

endmodule

@@ rtl/core/gradient_noise_2d_with_derivatives_unit.sv @@
// Two-dimensional gradient noise with analytic derivatives: nine-stage
// pipeline taking one transaction per clock. A transaction either loads one
// permutation entry, loads one gradient entry, or evaluates a signed Q16.16
// point and returns the noise value and both partial derivatives in
// saturated Q4.16. Load transactions, and those with the unused op code,
// produce no result. The pipeline takes a new transaction every cycle in
// which the result register is empty or being drained; a stalled result
// register holds the whole pipeline in place, so nothing is dropped or
// repeated. The tables are not cleared at reset: every entry must be loaded
// before an evaluation reads it. The user must write the seed through the
// configuration port while the block is idle; the block does not enforce it.
// Depends on gn2d_pkg, gn2d_hash, gn2d_fade and gn2d_blend.
module gradient_noise_2d_with_derivatives_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gn2d_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gn2d_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [11:0]          cfg_wdata
);

  logic                 en;
  logic                 v1_r;
  gn2d_pkg::in_item_t   item1_r;
  logic [11:0]          seed_r;
  logic                 eval4;
  gn2d_pkg::corner_grads_t grads4;
  logic [15:0]          fx4, fy4;
  logic signed [gn2d_pkg::UW-1:0] ux4, uy4, dux4, duy4;

  // The whole pipeline advances together whenever the result register can
  // move, so valid bits and data never part company.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // Stage 1: input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1_r <= in_data;
    end
  end

  // Stages 2 to 4: corner hashes and gradient lookups, in step with the fade
  // polynomials of both fractions.
  gn2d_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .seed   (gn2d_pkg::IDX_W'(seed_r)),
    .valid1 (v1_r),
    .item1  (item1_r),
    .eval4  (eval4),
    .grads4 (grads4)
  );

  gn2d_fade u_fade_x (
    .clk    (clk),
    .en     (en),
    .f_in   (item1_r.point_x[15:0]),
    .f_out  (fx4),
    .u_out  (ux4),
    .du_out (dux4)
  );

  gn2d_fade u_fade_y (
    .clk    (clk),
    .en     (en),
    .f_in   (item1_r.point_y[15:0]),
    .f_out  (fy4),
    .u_out  (uy4),
    .du_out (duy4)
  );

  // Stages 5 to 9: dot products, blend and saturation into the result
  // register.
  gn2d_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid4    (eval4),
    .g         (grads4),
    .fx        (fx4),
    .fy        (fy4),
    .ux        (ux4),
    .uy        (uy4),
    .dux       (dux4),
    .duy       (duy4),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

@@ rtl/core/gn2d_checker.sv @@
// Port-level checker for the gradient noise unit, bound to the top level.
// Depends on gn2d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gn2d_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input gn2d_pkg::out_item_t out_data
);

  `GN2D_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "result valid right after reset")
  `GN2D_ASSERT(a_ready_only_stalled, !in_ready |-> (out_valid && !out_ready), "input blocked without a stalled result")
  `GN2D_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "stalled result dropped")
  `GN2D_ASSERT(a_out_stable, (out_valid && !out_ready) |=> $stable(out_data), "stalled result changed")

endmodule

bind gradient_noise_2d_with_derivatives_unit gn2d_checker u_gn2d_checker (.*);

@@ bench/tb_gradient_noise_2d_with_derivatives_unit.sv @@
// Self-checking bench for the 2D gradient noise unit with derivatives.
// Depends on gn2d_pkg and gradient_noise_2d_with_derivatives_unit; reads no files.
module tb_gradient_noise_2d_with_derivatives_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_LAT   = 9;
  localparam int WATCH_LIM  = 20000;
  localparam int TS         = gn2d_pkg::TABLE_SIZE;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  gn2d_pkg::in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  gn2d_pkg::out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [11:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  gradient_noise_2d_with_derivatives_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the block state, updated as each transaction is accepted.
  logic [11:0] seed_shadow;
  logic [7:0]  perm_shadow [TS];
  logic [31:0] grad_shadow [TS];

  gn2d_pkg::in_item_t  pending_items [$];
  gn2d_pkg::out_item_t expected_samples [$];
  int  errors = 0;
  int  idle_cycles = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  hold_send = 1'b0;
  bit  stim_done = 1'b0;

  // Floor shift of a signed 64-bit value; >>> on a signed operand floors.
  function automatic longint fshift(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    return fshift(a * b + 32768, 16);
  endfunction

  function automatic longint clamp_q4(longint x);
    if (x > 524287) return 524287;
    if (x < -524288) return -524288;
    return x;
  endfunction

  function automatic longint quintic(longint f);
    longint f2, f3, inner;
    f2 = q16_mul(f, f);
    f3 = q16_mul(f2, f);
    inner = q16_mul(f, 6 * f - 15 * 65536) + 10 * 65536;
    return q16_mul(f3, inner);
  endfunction

  function automatic longint quintic_slope(longint f);
    longint f2, inner;
    f2 = q16_mul(f, f);
    inner = q16_mul(f, f - 2 * 65536) + 65536;
    return 30 * q16_mul(f2, inner);
  endfunction

  function automatic void lattice_grad(longint ix, longint iy,
                                       output longint gx, output longint gy);
    int c0, c1, h;
    logic [31:0] g;
    c0 = int'((ix + seed_shadow) & (TS - 1));
    c1 = int'((perm_shadow[c0] + iy + seed_shadow) & (TS - 1));
    h  = int'(perm_shadow[c1]);
    g  = grad_shadow[h];
    gx = longint'($signed(g[15:0]));
    gy = longint'($signed(g[31:16]));
  endfunction

  function automatic longint corner_dot(longint gx, longint gy, longint dx, longint dy);
    return fshift(gx * dx + gy * dy + 8192, 14);
  endfunction

  // Applies one accepted transaction to the shadow state and queues the
  // sample it should produce, if any.
  function automatic void noise_sample(gn2d_pkg::in_item_t it);
    longint px, py, ix, iy, fx, fy, ux, uy, uxy, dux, duy;
    longint ax, ay, bx, by, cx, cy, ex, ey;
    longint va, vb, vc, vd, k, v, dx, dy;
    gn2d_pkg::out_item_t r;
    case (it.op)
      gn2d_pkg::OP_WR_PERM: perm_shadow[it.table_index] = it.perm_value;
      gn2d_pkg::OP_WR_GRAD: grad_shadow[it.table_index] = {it.grad_y_in, it.grad_x_in};
      gn2d_pkg::OP_EVAL: begin
        px = longint'(it.point_x);
        py = longint'(it.point_y);
        ix = fshift(px, 16);
        iy = fshift(py, 16);
        fx = px & 64'hFFFF;
        fy = py & 64'hFFFF;
        ux = quintic(fx);
        uy = quintic(fy);
        uxy = q16_mul(ux, uy);
        dux = quintic_slope(fx);
        duy = quintic_slope(fy);
        lattice_grad(ix, iy, ax, ay);
        lattice_grad(ix + 1, iy, bx, by);
        lattice_grad(ix, iy + 1, cx, cy);
        lattice_grad(ix + 1, iy + 1, ex, ey);
        va = corner_dot(ax, ay, fx, fy);
        vb = corner_dot(bx, by, fx - 65536, fy);
        vc = corner_dot(cx, cy, fx, fy - 65536);
        vd = corner_dot(ex, ey, fx - 65536, fy - 65536);
        k = va - vb - vc + vd;
        v = va + q16_mul(ux, vb - va) + q16_mul(uy, vc - va) + q16_mul(uxy, k);
        ax *= 4; ay *= 4; bx *= 4; by *= 4; cx *= 4; cy *= 4; ex *= 4; ey *= 4;
        dx = ax + q16_mul(ux, bx - ax) + q16_mul(uy, cx - ax)
           + q16_mul(uxy, ax - bx - cx + ex) + q16_mul(dux, q16_mul(uy, k) + vb - va);
        dy = ay + q16_mul(ux, by - ay) + q16_mul(uy, cy - ay)
           + q16_mul(uxy, ay - by - cy + ey) + q16_mul(duy, q16_mul(ux, k) + vc - va);
        r.noise_value = 20'(clamp_q4(v));
        r.deriv_x = 20'(clamp_q4(dx));
        r.deriv_y = 20'(clamp_q4(dy));
        expected_samples.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver. The item is applied to the shadow model when it is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        noise_sample(in_data);
        gap_left = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || hold_send || pending_items.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end
      end
    end
  end

  // Monitor and result-side stall generator.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: expected no sample, got %h", $realtime, out_data);
          errors++;
        end else begin
          gn2d_pkg::out_item_t e;
          e = expected_samples.pop_front();
          if (e.noise_value !== out_data.noise_value)
            $display("%0t: noise_value expected %0d got %0d", $realtime,
                     e.noise_value, out_data.noise_value);
          if (e.deriv_x !== out_data.deriv_x)
            $display("%0t: deriv_x expected %0d got %0d", $realtime,
                     e.deriv_x, out_data.deriv_x);
          if (e.deriv_y !== out_data.deriv_y)
            $display("%0t: deriv_y expected %0d got %0d", $realtime,
                     e.deriv_y, out_data.deriv_y);
          if (e !== out_data) errors++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_LIM) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic gn2d_pkg::in_item_t eval_item(logic [31:0] x, logic [31:0] y);
    gn2d_pkg::in_item_t it;
    it = '0;
    it.op = gn2d_pkg::OP_EVAL;
    it.point_x = x;
    it.point_y = y;
    it.table_index = 8'($urandom());
    it.perm_value = 8'($urandom());
    it.grad_x_in = 16'($urandom());
    return it;
  endfunction

  function automatic gn2d_pkg::in_item_t grad_item(logic [7:0] idx, logic [15:0] gx,
                                                   logic [15:0] gy);
    gn2d_pkg::in_item_t it;
    it = '0;
    it.op = gn2d_pkg::OP_WR_GRAD;
    it.table_index = idx;
    it.grad_x_in = gx;
    it.grad_y_in = gy;
    it.point_x = $urandom();
    return it;
  endfunction

  function automatic gn2d_pkg::in_item_t perm_item(logic [7:0] idx, logic [7:0] val);
    gn2d_pkg::in_item_t it;
    it = '0;
    it.op = gn2d_pkg::OP_WR_PERM;
    it.table_index = idx;
    it.perm_value = val;
    it.point_y = $urandom();
    return it;
  endfunction

  // Gradient values: extremes, any bit pattern, or the usual Q1.14 range.
  function automatic logic [15:0] rand_grad();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom());
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_point();
    case ($urandom_range(0, 5))
      0: return {16'($urandom_range(0, 7) - 4), 16'($urandom())};
      1: return $urandom();
      2: return {16'($urandom()), 16'hFFFF};
      default: return {16'($urandom_range(0, 40) - 20), 16'($urandom())};
    endcase
  endfunction

  // Waits until the pipeline has drained, then writes the seed register.
  task automatic write_seed(logic [11:0] val);
    wait (pending_items.size() == 0 && !in_valid && expected_samples.size() == 0);
    repeat (PIPE_LAT + 2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    seed_shadow = val;
  endtask

  initial begin
    gn2d_pkg::in_item_t op3;
    int n;
    seed_shadow = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill both tables completely so no evaluation reads an unloaded entry.
    for (int i = 0; i < TS; i++) begin
      pending_items.push_back(perm_item(8'(i), 8'($urandom())));
      pending_items.push_back(grad_item(8'(i), rand_grad(), rand_grad()));
    end
    write_seed(12'd0);

    // Directed part: corner points, fraction extremes, odd gradients, unused op.
    pending_items.push_back(grad_item(8'd0, 16'h7FFF, 16'h8000));
    pending_items.push_back(grad_item(8'd255, 16'h8000, 16'h7FFF));
    pending_items.push_back(perm_item(8'd255, 8'd0));
    pending_items.push_back(perm_item(8'd0, 8'd255));
    pending_items.push_back(eval_item(32'h0000_0000, 32'h0000_0000));
    pending_items.push_back(eval_item(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_items.push_back(eval_item(32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(eval_item(32'hFFFF_FFFF, 32'h0000_FFFF));
    pending_items.push_back(eval_item(32'h0000_8000, 32'hFFFF_8000));
    pending_items.push_back(eval_item(32'h0001_0000, 32'hFFFF_0000));
    op3 = eval_item(32'h1234_5678, 32'h9ABC_DEF0);
    op3.op = gn2d_pkg::op_t'(2'd3);
    pending_items.push_back(op3);
    pending_items.push_back(eval_item(32'h0000_0001, 32'h0000_0001));

    // Random phases over several seeds, extremes included.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_seed(12'd4095);
        1: write_seed(12'd1);
        2: write_seed(12'($urandom()));
        3: write_seed(12'd256);
        default: write_seed(12'd0);
      endcase
      for (n = 0; n < 155; n++) begin
        case ($urandom_range(0, 19))
          0: pending_items.push_back(perm_item(8'($urandom()), 8'($urandom())));
          1: pending_items.push_back(grad_item(8'($urandom()), rand_grad(), rand_grad()));
          2: begin
            op3 = eval_item(rand_point(), rand_point());
            op3.op = gn2d_pkg::op_t'(2'd3);
            pending_items.push_back(op3);
          end
          default: pending_items.push_back(eval_item(rand_point(), rand_point()));
        endcase
        // Once per phase, hold the sender until the pipeline has emptied.
        if (n == 77) begin
          wait (pending_items.size() == 0 && !in_valid);
          hold_send = 1'b1;
          wait (expected_samples.size() == 0);
          hold_send = 1'b0;
        end
      end
    end

    wait (pending_items.size() == 0 && !in_valid);
    fork
      wait (expected_samples.size() == 0);
      begin
        repeat (WATCH_LIM) @(posedge clk);
      end
    join_any
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
